/* sv/wildcard_star_regex_matcher_unit_defines.svh */
// ----------------------------------------------------------------------------
// wildcard star regex matcher assertion macros
// shared concurrent assertion forms, all reset-qualified on rst_n
// ----------------------------------------------------------------------------
`ifndef WILDCARD_STAR_REGEX_MATCHER_UNIT_DEFINES_SVH
`define WILDCARD_STAR_REGEX_MATCHER_UNIT_DEFINES_SVH

// condition holds at every clock edge out of reset
`define WSRM_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define WSRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/wsrm_pkg.sv */
// ----------------------------------------------------------------------------
// wsrm_pkg
// shared types and constants of the wildcard star regex matcher
// ----------------------------------------------------------------------------
`default_nettype none

package wsrm_pkg;

    // token store size and derived widths
    localparam int MAX_TOKENS = 32;
    localparam int POS_W      = MAX_TOKENS + 1;
    localparam int CNT_W      = $clog2(MAX_TOKENS + 1);
    localparam int TOK_IDX_W  = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;

    // special pattern bytes
    localparam logic [7:0] STAR_CHAR = 8'h2A;
    localparam logic [7:0] DOT_CHAR  = 8'h2E;

    // stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_PATTERN = 2'd1,
        OP_RESTART = 2'd2,
        OP_TEXT    = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic pattern_error;
        logic still_alive;
        logic matched;
    } result_t;

endpackage

`default_nettype wire

/* sv/wsrm_engine.sv */
// ----------------------------------------------------------------------------
// wsrm_engine
// pattern token store, star marks and bit-parallel nfa active set;
// one item is applied per fire, result is combinational from the item
// ----------------------------------------------------------------------------
`default_nettype none
`include "wildcard_star_regex_matcher_unit_defines.svh"

module wsrm_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  wsrm_pkg::item_t   item,
    output wsrm_pkg::result_t result
);
    import wsrm_pkg::*;

    // star closure as a carry chain: starred token generates from an active
    // position and propagates an incoming carry
    function automatic logic [POS_W-1:0] star_closure(
        input logic [POS_W-1:0]      set,
        input logic [MAX_TOKENS-1:0] star
    );
        logic [POS_W:0] a_op;
        logic [POS_W:0] g_op;
        logic [POS_W:0] sum;
        logic [POS_W:0] carries;
        a_op    = {2'b00, star};
        g_op    = {1'b0, set} & a_op;
        sum     = a_op + g_op;
        carries = sum ^ a_op ^ g_op;
        return set | carries[POS_W-1:0];
    endfunction

    logic [7:0]            tok_reg [MAX_TOKENS];
    logic [MAX_TOKENS-1:0] star_reg;
    logic [MAX_TOKENS-1:0] star_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [POS_W-1:0]      act_reg;
    logic [POS_W-1:0]      act_next;
    logic                  err_reg;
    logic                  err_next;

    logic                  tok_we;
    logic                  is_star;
    logic [TOK_IDX_W-1:0]  last_idx;
    logic [MAX_TOKENS-1:0] tok_mask;
    logic [MAX_TOKENS-1:0] hit;
    logic [POS_W-1:0]      stepped;

    assign is_star  = (item.data_byte == STAR_CHAR);
    assign last_idx = TOK_IDX_W'(count_reg - CNT_W'(1));

    // pattern parse
    always_comb
    begin
        star_next  = star_reg;
        count_next = count_reg;
        err_next   = err_reg;
        tok_we     = 1'b0;
        unique case (item.op)
            OP_CLEAR:
            begin
                star_next  = '0;
                count_next = '0;
                err_next   = 1'b0;
            end
            OP_PATTERN:
            begin
                priority if (err_reg)
                begin
                    err_next = 1'b1;
                end
                else if (is_star && (count_reg == '0))
                begin
                    err_next = 1'b1;
                end
                else if (is_star && !star_reg[last_idx])
                begin
                    star_next[last_idx] = 1'b1;
                end
                else if (count_reg >= CNT_W'(MAX_TOKENS))
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    tok_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_RESTART, OP_TEXT:
            begin
            end
        endcase
    end

    // per-token byte compare, limited to loaded tokens
    always_comb
    begin
        for (int k = 0; k < MAX_TOKENS; k++)
        begin
            tok_mask[k] = (CNT_W'(k) < count_reg);
            hit[k]      = act_reg[k] && tok_mask[k] &&
                          ((tok_reg[k] == DOT_CHAR) || (tok_reg[k] == item.data_byte));
        end
    end

    // starred tokens stay put, plain tokens advance one position
    assign stepped = {1'b0, hit & star_reg} | {hit & ~star_reg, 1'b0};

    // active set update
    always_comb
    begin
        unique case (item.op)
            OP_TEXT:
            begin
                act_next = err_reg ? '0 : star_closure(stepped, star_reg);
            end
            OP_CLEAR, OP_PATTERN, OP_RESTART:
            begin
                act_next = err_next ? '0 : star_closure(POS_W'(1), star_next);
            end
        endcase
    end

    assign result.matched       = !err_next && act_next[count_next];
    assign result.still_alive   = !err_next && (act_next != '0);
    assign result.pattern_error = err_next;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            star_reg  <= '0;
            count_reg <= '0;
            act_reg   <= POS_W'(1);
            err_reg   <= 1'b0;
        end
        else if (fire)
        begin
            star_reg  <= star_next;
            count_reg <= count_next;
            act_reg   <= act_next;
            err_reg   <= err_next;
        end
    end

    // token byte store, written at the fill position
    always_ff @(posedge clk)
    begin
        if (fire && tok_we)
        begin
            tok_reg[count_reg[TOK_IDX_W-1:0]] <= item.data_byte;
        end
    end

    `WSRM_ASSERT_ALWAYS(a_err_empty, clk, rst_n, (!err_reg || (act_reg == '0)), "error with live positions")
    `WSRM_ASSERT_ALWAYS(a_count_range, clk, rst_n, (count_reg <= CNT_W'(MAX_TOKENS)), "token count overflow")
    `WSRM_ASSERT_ALWAYS(a_star_loaded, clk, rst_n, ((star_reg & ~tok_mask) == '0), "star mark beyond loaded tokens")
    `WSRM_ASSERT_ALWAYS(a_act_loaded, clk, rst_n, ((act_reg & ~{tok_mask, 1'b1}) == '0), "active position beyond pattern end")
    `WSRM_ASSERT_NEXT(a_clear_start, clk, rst_n, (fire && (item.op == OP_CLEAR)), (!err_reg && act_reg[0]), "clear did not restart nfa")

endmodule

`default_nettype wire

/* sv/wildcard_star_regex_matcher_unit.sv */
// ----------------------------------------------------------------------------
// wildcard_star_regex_matcher_unit
// whole-string matcher for literal, '.' and postfix '*' patterns, one
// result transaction per input transaction
// ----------------------------------------------------------------------------
//  channel  dir  fields (low first)                               per
//  s_axis   in   tdata: data_byte[7:0]; tuser: op[1:0]            item
//  m_axis   out  tdata: matched[0], still_alive[1], pattern_error[2] result
//
//  one transaction per cycle sustained while m_tready stays high; input register, then result register
//  the nfa step and star closure (a 34-bit carry chain) sit between the
//  input register and the result register
//  reset clears pattern, error and leaves only position zero active
//  a stalled result holds while the input register keeps one more item
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_star_regex_matcher_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [wsrm_pkg::IN_TDATA_W-1:0]    s_tdata,  // data_byte
    input  logic [wsrm_pkg::IN_TUSER_W-1:0]    s_tuser,  // op
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [wsrm_pkg::OUT_TDATA_W-1:0]   m_tdata   // matched, still_alive, pattern_error
);
    import wsrm_pkg::*;

    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_res_reg;
    result_t eng_res;
    logic    advance;
    logic    fire;

    // pipeline flow control
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.op        <= op_t'(s_tuser);
            in_item_reg.data_byte <= s_tdata;
        end
        if (fire)
        begin
            out_res_reg <= eng_res;
        end
    end

    wsrm_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .result (eng_res)
    );

    // result stream
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - 3)'(0), out_res_reg.pattern_error,
                       out_res_reg.still_alive, out_res_reg.matched};

endmodule

`default_nettype wire

/* test/tb_wildcard_star_regex_matcher_unit.sv */
// ----------------------------------------------------------------------------
// tb_wildcard_star_regex_matcher_unit
// self-checking regression for the wildcard star regex matcher: a scoreboard
// predicts each result from the accepted input transactions and compares it
// field by field; directed pattern cases come first, then random sessions
// of clear, pattern bytes, restarts and text, with random stalls on both
// streams, one long output stall and a final stretch at full rate
// ----------------------------------------------------------------------------
`default_nettype none

module tb_wildcard_star_regex_matcher_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import wsrm_pkg::*;

    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_C = 8'h63;
    localparam logic [7:0] CH_X = 8'h78;
    localparam int HOLD_CYCLES  = 200;
    localparam int MAX_TEXT     = 20;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // data_byte
    logic [IN_TUSER_W-1:0]  s_tuser;   // op
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // matched, still_alive, pattern_error, zero pad

    // flow control knobs
    bit src_idle_en;
    bit sink_idle_en;
    bit hold_req;

    // scoreboard state
    result_t     match_expect_q[$];
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned fail_count;

    // predicted pattern store and nfa
    logic [7:0]            pat_tok [MAX_TOKENS];
    logic [MAX_TOKENS-1:0] pat_star;
    int                    pat_len;
    logic [POS_W-1:0]      nfa_active;
    bit                    pat_err;

    wildcard_star_regex_matcher_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(5_000_000);
        $display("wildcard_star_regex_matcher_unit regression: fail");
        $finish;
    end

    // starred positions may be skipped, rippling upward
    function automatic logic [POS_W-1:0] star_closure(logic [POS_W-1:0] s);
        int k;
        for (k = 0; k < pat_len; k++)
            if (s[k] && pat_star[k])
                s[k+1] = 1'b1;
        return s;
    endfunction

    function automatic void text_restart();
        nfa_active = pat_err ? '0 : star_closure(POS_W'(1));
    endfunction

    // advance the predicted matcher by one transaction
    function automatic result_t matcher_step(op_t op, logic [7:0] b);
        logic [POS_W-1:0] next_set;
        result_t          r;
        int               k;
        case (op)
            OP_CLEAR:
            begin
                pat_len  = 0;
                pat_star = '0;
                pat_err  = 1'b0;
                text_restart();
            end
            OP_PATTERN:
            begin
                if (!pat_err)
                begin
                    if (b == STAR_CHAR && pat_len == 0)
                        pat_err = 1'b1;
                    else if (b == STAR_CHAR && !pat_star[pat_len-1])
                        pat_star[pat_len-1] = 1'b1;
                    else if (pat_len >= MAX_TOKENS)
                        pat_err = 1'b1;
                    else
                    begin
                        pat_tok[pat_len]  = b;
                        pat_star[pat_len] = 1'b0;
                        pat_len++;
                    end
                end
                text_restart();
            end
            OP_RESTART:
                text_restart();
            OP_TEXT:
            begin
                if (pat_err)
                    nfa_active = '0;
                else
                begin
                    next_set = '0;
                    for (k = 0; k < pat_len; k++)
                        if (nfa_active[k] && (pat_tok[k] == DOT_CHAR || pat_tok[k] == b))
                        begin
                            if (pat_star[k])
                                next_set[k] = 1'b1;
                            else
                                next_set[k+1] = 1'b1;
                        end
                    nfa_active = star_closure(next_set);
                end
            end
        endcase
        r.matched       = !pat_err && nfa_active[pat_len];
        r.still_alive   = !pat_err && (nfa_active != '0);
        r.pattern_error = pat_err;
        return r;
    endfunction

    // scoreboard: predict on input transaction, compare on output transaction
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                match_expect_q.push_back(matcher_step(op_t'(s_tuser), s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[2:0]);
                results_seen++;
                if (match_expect_q.size() == 0)
                begin
                    $error("unexpected result transaction %b", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = match_expect_q.pop_front();
                    if (got.matched !== want.matched)
                    begin
                        $error("matched: expected %b, got %b", want.matched, got.matched);
                        fail_count++;
                    end
                    if (got.still_alive !== want.still_alive)
                    begin
                        $error("still_alive: expected %b, got %b",
                               want.still_alive, got.still_alive);
                        fail_count++;
                    end
                    if (got.pattern_error !== want.pattern_error)
                    begin
                        $error("pattern_error: expected %b, got %b",
                               want.pattern_error, got.pattern_error);
                        fail_count++;
                    end
                end
            end
        end
    end

    // result sink with random stalls and one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (sink_idle_en && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // send one transaction, with an optional idle burst ahead of it
    task automatic push_item(op_t op, logic [7:0] b);
        if (src_idle_en && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic wait_for_results();
        while (results_seen < items_sent)
            @(posedge clk);
    endtask

    // every op, data extremes, star rules, error and dead-text handling
    task automatic test_directed_basics();
        push_item(OP_TEXT, 8'h00);          // empty pattern, one byte: dead
        push_item(OP_RESTART, 8'hFF);       // empty text matches empty pattern
        push_item(OP_CLEAR, 8'h5A);
        push_item(OP_PATTERN, STAR_CHAR);   // leading star
        push_item(OP_PATTERN, CH_A);        // ignored while in error
        push_item(OP_TEXT, CH_A);
        push_item(OP_RESTART, 8'h00);
        push_item(OP_CLEAR, 8'h00);
        // pattern a* then literal star starred, then dot, then 0xff
        push_item(OP_PATTERN, CH_A);
        push_item(OP_PATTERN, STAR_CHAR);   // stars the a
        push_item(OP_PATTERN, STAR_CHAR);   // literal star
        push_item(OP_PATTERN, STAR_CHAR);   // stars the literal star
        push_item(OP_PATTERN, DOT_CHAR);
        push_item(OP_PATTERN, 8'hFF);
        push_item(OP_RESTART, 8'h33);
        push_item(OP_TEXT, CH_A);
        push_item(OP_TEXT, STAR_CHAR);
        push_item(OP_TEXT, 8'h00);
        push_item(OP_TEXT, 8'hFF);          // full match
        push_item(OP_TEXT, 8'hFF);          // dead
        push_item(OP_TEXT, CH_A);           // stays dead
        push_item(OP_RESTART, 8'hFF);
    endtask

    // fill the token store, match through all positions, then overflow
    task automatic test_token_overflow();
        logic [7:0] fill [MAX_TOKENS];
        int         i;
        push_item(OP_CLEAR, 8'h00);
        for (i = 0; i < MAX_TOKENS; i++)
        begin
            if (i == 0)
                fill[i] = 8'h00;
            else if (i == MAX_TOKENS - 1)
                fill[i] = 8'hFF;
            else
            begin
                fill[i] = 8'($urandom_range(0, 255));
                if (fill[i] == STAR_CHAR || fill[i] == DOT_CHAR)
                    fill[i] = CH_X;
            end
            push_item(OP_PATTERN, fill[i]);
        end
        push_item(OP_PATTERN, STAR_CHAR);   // stars the last token, no overflow
        push_item(OP_RESTART, 8'h00);
        for (i = 0; i < MAX_TOKENS - 1; i++)
            push_item(OP_TEXT, fill[i]);
        push_item(OP_TEXT, 8'hFF);
        push_item(OP_TEXT, 8'hFF);
        push_item(OP_PATTERN, STAR_CHAR);   // literal star would be token 33
        push_item(OP_PATTERN, CH_B);
        push_item(OP_TEXT, CH_B);
        push_item(OP_RESTART, 8'h00);
        push_item(OP_CLEAR, 8'hFF);
    endtask

    // long result stall while the source keeps offering, then drain
    task automatic test_output_stall();
        int i;
        src_idle_en = 1'b0;
        hold_req    = 1'b1;
        push_item(OP_CLEAR, 8'h00);
        push_item(OP_PATTERN, DOT_CHAR);
        push_item(OP_PATTERN, STAR_CHAR);
        push_item(OP_PATTERN, CH_C);
        push_item(OP_RESTART, 8'h00);
        for (i = 0; i < 25; i++)
            push_item(OP_TEXT, ($urandom_range(0, 3) == 0) ? CH_C : 8'($urandom_range(0, 255)));
        wait_for_results();
        src_idle_en = 1'b1;
    endtask

    // one random session: well-formed pattern and texts, broken pattern, or noise
    task automatic run_session();
        logic [7:0] tok_b [MAX_TOKENS];
        bit         tok_s [MAX_TOKENS];
        logic [7:0] txt[$];
        logic [7:0] b;
        int         kind, n, i, j, reps, t;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            // noise
            n = $urandom_range(1, 10);
            for (i = 0; i < n; i++)
                push_item(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
        else if (kind < 12)
        begin
            // leading star, then junk
            push_item(OP_CLEAR, 8'($urandom_range(0, 255)));
            push_item(OP_PATTERN, STAR_CHAR);
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++)
                push_item(OP_PATTERN, 8'($urandom_range(0, 255)));
            push_item(OP_RESTART, 8'($urandom_range(0, 255)));
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
                push_item(OP_TEXT, 8'($urandom_range(0, 255)));
        end
        else if (kind < 14)
        begin
            // too many tokens
            push_item(OP_CLEAR, 8'($urandom_range(0, 255)));
            n = $urandom_range(MAX_TOKENS + 1, MAX_TOKENS + 4);
            for (i = 0; i < n; i++)
            begin
                b = 8'($urandom_range(0, 255));
                push_item(OP_PATTERN, (b == STAR_CHAR) ? CH_X : b);
            end
            push_item(OP_RESTART, 8'($urandom_range(0, 255)));
            push_item(OP_TEXT, 8'($urandom_range(0, 255)));
        end
        else
        begin
            // well-formed pattern
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, MAX_TOKENS)
                                             : $urandom_range(0, 8);
            push_item(OP_CLEAR, 8'($urandom_range(0, 255)));
            for (i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: b = CH_A;
                    4, 5:       b = CH_B;
                    6, 7:       b = DOT_CHAR;
                    8:          b = 8'($urandom_range(0, 255));
                    default:    b = (i > 0 && tok_s[i-1]) ? STAR_CHAR : CH_C;
                endcase
                // a literal star may only follow a starred token
                if (b == STAR_CHAR && !(i > 0 && tok_s[i-1]))
                    b = CH_C;
                tok_b[i] = b;
                tok_s[i] = ($urandom_range(0, 2) == 0);
                push_item(OP_PATTERN, b);
                if (tok_s[i])
                    push_item(OP_PATTERN, STAR_CHAR);
            end
            // texts built from the tokens, some of them corrupted
            t = $urandom_range(1, 4);
            for (j = 0; j < t; j++)
            begin
                txt.delete();
                for (i = 0; i < n; i++)
                begin
                    reps = tok_s[i] ? $urandom_range(0, 3) : 1;
                    repeat (reps)
                        txt.push_back((tok_b[i] == DOT_CHAR) ? 8'($urandom_range(0, 255))
                                                             : tok_b[i]);
                end
                for (i = 0; i < txt.size(); i++)
                    if ($urandom_range(0, 11) == 0)
                        txt[i] = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 5) == 0)
                    txt.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 7) == 0 && txt.size() > 0)
                    void'(txt.pop_back());
                push_item(OP_RESTART, 8'($urandom_range(0, 255)));
                for (i = 0; i < txt.size() && i < MAX_TEXT; i++)
                    push_item(OP_TEXT, txt[i]);
            end
        end
    endtask

    // random sessions until the item goal, idling as requested
    task automatic test_random_sessions(int unsigned item_goal, bit throttle);
        while (items_sent < item_goal)
        begin
            src_idle_en  = throttle && ($urandom_range(0, 3) != 0);
            sink_idle_en = throttle && ($urandom_range(0, 3) != 0);
            run_session();
            if ($urandom_range(0, 9) == 0)
                wait_for_results();
        end
    endtask

    // stimulus
    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        hold_req     = 1'b0;
        items_sent   = 0;
        results_seen = 0;
        fail_count   = 0;
        pat_len      = 0;
        pat_star     = '0;
        pat_err      = 1'b0;
        nfa_active   = POS_W'(1);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_basics();
        wait_for_results();
        test_token_overflow();
        wait_for_results();
        test_output_stall();
        test_random_sessions(1700, 1'b1);
        wait_for_results();
        test_random_sessions(1850, 1'b0);
        s_tvalid <= 1'b0;
        wait_for_results();
        repeat (8) @(posedge clk);

        if (match_expect_q.size() != 0)
        begin
            $error("%0d expected results never arrived", match_expect_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("wildcard_star_regex_matcher_unit regression: pass");
        else
            $display("wildcard_star_regex_matcher_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+sv
sv/wsrm_pkg.sv
sv/wsrm_engine.sv
sv/wildcard_star_regex_matcher_unit.sv
test/tb_wildcard_star_regex_matcher_unit.sv
